// ===== rtl/core/sapq_pkg.sv =====
package sapq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned HELD_W  = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [VALUE_W-1:0] EMPTY_REMOVE_VALUE = '1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } sapq_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic execute;
  } sapq_cmd_t;

endpackage

// ===== rtl/core/sapq_in_if.sv =====
interface sapq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

// ===== rtl/core/sapq_out_if.sv =====
interface sapq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] removed_value;
  logic [4:0]  held_after;

  modport source (output valid, output status, output removed_value, output held_after,
                  input ready);
  modport sink (input valid, input status, input removed_value, input held_after,
                output ready);
endinterface

// ===== rtl/core/sorted_array_priority_queue_core.sv =====
// Sorted-array min-priority queue.
// Each accepted transaction passes the controller's load, execute and respond steps;
// the result is registered on execute and held valid in respond until taken, and no
// new input is accepted until then. All cells shift together in the execute step.
// Reset (synchronous, active high) empties the queue; stored values are not cleared.
module sorted_array_priority_queue_core
  import sapq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  sapq_in_if.sink    in_ch,
  sapq_out_if.source out_ch
);

  sapq_cmd_t cmd;

  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sapq_datapath #(
    .DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_op         (in_ch.op),
    .in_value      (in_ch.value),
    .status        (out_ch.status),
    .removed_value (out_ch.removed_value),
    .held_after    (out_ch.held_after)
  );

endmodule

// ===== rtl/core/sapq_ctrl.sv =====
module sapq_ctrl
  import sapq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sapq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_RESP;
      S_RESP: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_RESP);
  assign cmd.load    = in_ready && in_valid;
  assign cmd.execute = (state == S_EXEC);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_exec_to_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid)
    else $error("result not presented after execution");

  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.execute)
    else $error("accepted transaction not executed");

endmodule

// ===== rtl/core/sapq_datapath.sv =====
module sapq_datapath
  import sapq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  sapq_cmd_t          cmd,
  input  logic               in_op,
  input  logic [VALUE_W-1:0] in_value,
  output logic [1:0]         status,
  output logic [VALUE_W-1:0] removed_value,
  output logic [HELD_W-1:0]  held_after
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic               op_q;
  logic [VALUE_W-1:0] value_q;
  logic [VALUE_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]   occupied;
  logic [DEPTH-1:0]   lt;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW+HELD_W-1:0] count_wide;
  logic               full;
  logic               empty;
  logic               do_insert;
  logic               do_remove;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= in_op;
      value_q <= in_value;
    end
  end

  assign full      = occupied[DEPTH-1];
  assign empty     = !occupied[0];
  assign do_insert = cmd.execute && (op_q == OP_INSERT) && !full;
  assign do_remove = cmd.execute && (op_q == OP_REMOVE) && !empty;

  // Each cell compares against the new value; the held values are ascending, so
  // lt is a prefix mask and the new value lands at its first clear bit.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign lt[i] = occupied[i] && ($signed(entry[i]) < $signed(value_q));

    always_ff @(posedge clk) begin
      if (do_insert && !lt[i]) begin
        if (i == 0) begin
          entry[i] <= value_q;
        end else begin
          entry[i] <= lt[(i == 0) ? 0 : i-1] ? value_q : entry[(i == 0) ? 0 : i-1];
        end
      end else if (do_remove && (i < DEPTH-1)) begin
        entry[i] <= entry[(i < DEPTH-1) ? i+1 : i];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CW'(1);
    end else if (do_remove) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
      count    <= '0;
    end else begin
      count <= count_next;
      if (do_insert) begin
        occupied <= {occupied[DEPTH-2:0], 1'b1};
      end else if (do_remove) begin
        occupied <= occupied >> 1;
      end
    end
  end

  assign count_wide = (CW+HELD_W)'(count_next);

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      held_after    <= count_wide[HELD_W-1:0];
      removed_value <= '0;
      status        <= ST_DONE;
      if (op_q == OP_INSERT) begin
        if (full) begin
          status <= ST_FULL;
        end
      end else if (empty) begin
        status        <= ST_EMPTY;
        removed_value <= EMPTY_REMOVE_VALUE;
      end else begin
        removed_value <= entry[0];
      end
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(occupied) == count)
    else $error("fill count disagrees with occupancy");

  a_thermometer: assert property (@(posedge clk) disable iff (rst)
    ((occupied >> 1) & ~occupied) == '0)
    else $error("occupancy has a hole");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && (op_q == OP_INSERT) && full) |=> $stable(occupied))
    else $error("dropped insert changed the queue");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sapq_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    logic                       op;
    logic signed [VALUE_W-1:0]  value;
  } queue_request_t;

  typedef struct {
    sapq_status_t       status;
    logic [VALUE_W-1:0] removed_value;
    logic [HELD_W-1:0]  held_after;
  } queue_result_t;

  logic clk;
  logic rst;

  sapq_in_if  in_ch ();
  sapq_out_if out_ch ();

  sorted_array_priority_queue_core #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Our own copy of the queue contents, kept in ascending order.
  logic signed [VALUE_W-1:0] held_sorted [DEPTH];
  int                        held_num;

  queue_request_t pending_items [$];
  queue_result_t  result_queue [$];

  int err_count;
  int items_accepted;
  bit offer_live;
  int send_gap;
  int recv_gap;
  bit sink_hold;
  bit steady_run;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic queue_result_t apply_queue_op(queue_request_t req);
    queue_result_t res;
    int            pos;
    res.status = ST_DONE;
    res.removed_value = '0;
    if (req.op == OP_INSERT) begin
      if (held_num >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // A new value goes ahead of any values equal to it.
        pos = held_num;
        while (pos > 0 && req.value <= held_sorted[pos-1]) begin
          held_sorted[pos] = held_sorted[pos-1];
          pos--;
        end
        held_sorted[pos] = req.value;
        held_num++;
      end
    end else if (held_num == 0) begin
      res.status = ST_EMPTY;
      res.removed_value = EMPTY_REMOVE_VALUE;
    end else begin
      res.removed_value = held_sorted[0];
      for (int i = 1; i < held_num; i++) begin
        held_sorted[i-1] = held_sorted[i];
      end
      held_num--;
    end
    res.held_after = HELD_W'(held_num);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("ERROR at %0t: %s: got %h, wanted %h", $time, what, got, want);
  endtask

  task automatic queue_item(input logic op, input logic [VALUE_W-1:0] value);
    queue_request_t req;
    req.op = op;
    req.value = value;
    pending_items.push_back(req);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = VALUE_W'($urandom_range(0, 6)) - 32'd3;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      2: v = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
      3: v = VALUE_W'($urandom_range(0, 40)) - 32'd20;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Random traffic in runs that lean toward filling, draining or neither, so
  // the queue keeps hitting both its full and its empty boundary.
  task automatic push_random_items(input int count);
    int left;
    int run_len;
    int insert_pct;
    left = count;
    while (left > 0) begin
      run_len = $urandom_range(20, 60);
      if (run_len > left) run_len = left;
      case ($urandom_range(0, 2))
        0: insert_pct = 80;
        1: insert_pct = 20;
        default: insert_pct = 50;
      endcase
      for (int i = 0; i < run_len; i++) begin
        queue_item(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                   pick_value());
      end
      left -= run_len;
    end
  endtask

  task automatic wait_for_drain();
    while (pending_items.size() != 0 || result_queue.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Input side: acceptance and prediction at the rising edge.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      result_queue.push_back(apply_queue_op(pending_items[0]));
      pending_items.pop_front();
      offer_live = 1'b0;
      items_accepted++;
    end
  end

  // Input driver.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!offer_live) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!steady_run && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 2);
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.op <= pending_items[0].op;
        in_ch.value <= pending_items[0].value;
        offer_live = 1'b1;
      end
    end
  end

  // Output ready driver.
  always @(negedge clk) begin
    if (rst || sink_hold) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else if (!steady_run && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Output monitor: each result transaction is checked against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    queue_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (result_queue.size() == 0) begin
        report_mismatch("result with none pending", {30'd0, out_ch.status}, '0);
      end else begin
        want = result_queue.pop_front();
        if (out_ch.status !== want.status) begin
          report_mismatch("status", {30'd0, out_ch.status}, {30'd0, want.status});
        end
        if (out_ch.removed_value !== want.removed_value) begin
          report_mismatch("removed_value", out_ch.removed_value, want.removed_value);
        end
        if (out_ch.held_after !== want.held_after) begin
          report_mismatch("held_after", {27'd0, out_ch.held_after},
                          {27'd0, want.held_after});
        end
      end
    end
  end

  // Long receiver stall in the middle of the random traffic; the sender keeps
  // offering, so the block backs up and stops taking input.
  initial begin
    sink_hold = 1'b0;
    while (items_accepted < 400) @(posedge clk);
    sink_hold = 1'b1;
    repeat (80) @(posedge clk);
    sink_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.op = OP_INSERT;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    held_num = 0;
    err_count = 0;
    items_accepted = 0;
    offer_live = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    steady_run = 1'b0;

    // Remove from an empty queue, with a nonzero value that must be ignored.
    queue_item(OP_REMOVE, 32'h1234_5678);
    // Extremes, zero, -1 and equal values.
    queue_item(OP_INSERT, 32'h7FFF_FFFF);
    queue_item(OP_INSERT, 32'h8000_0000);
    queue_item(OP_INSERT, 32'h0000_0000);
    queue_item(OP_INSERT, 32'hFFFF_FFFF);
    queue_item(OP_INSERT, 32'h0000_0001);
    queue_item(OP_INSERT, 32'hFFFF_FFFF);
    queue_item(OP_INSERT, 32'h8000_0000);
    queue_item(OP_INSERT, 32'h7FFF_FFFF);
    queue_item(OP_REMOVE, 32'hFFFF_FFFF);
    // Fill the queue to its depth.
    queue_item(OP_INSERT, 32'd5);
    queue_item(OP_INSERT, -32'sd5);
    queue_item(OP_INSERT, 32'd0);
    queue_item(OP_INSERT, 32'd0);
    queue_item(OP_INSERT, 32'd100);
    queue_item(OP_INSERT, -32'sd100);
    queue_item(OP_INSERT, 32'h7FFF_FFFE);
    queue_item(OP_INSERT, 32'h8000_0001);
    queue_item(OP_INSERT, 32'd3);
    // Inserts into a full queue are dropped.
    queue_item(OP_INSERT, 32'd42);
    queue_item(OP_INSERT, 32'h8000_0000);
    repeat (4) queue_item(OP_REMOVE, 32'd0);

    push_random_items(600);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sender pauses until every result has come back.
    wait_for_drain();
    push_random_items(525);

    // Final stretch runs with no idling on either side.
    wait_for_drain();
    steady_run = 1'b1;
    push_random_items(150);

    while (pending_items.size() != 0 || result_queue.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
